[sv/dnv_pkg.sv]
// shared types, constants and character classification for the domain name validator
`default_nettype none

package dnv_pkg;

    localparam int NAME_LEN_W  = 10;
    localparam int LABEL_LEN_W = 8;
    localparam int CHAR_W      = 8;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int OUT_DATA_W  = 8;

    localparam logic [NAME_LEN_W-1:0]  MAX_NAME_LEN_RST  = 10'd253;
    localparam logic [LABEL_LEN_W-1:0] MAX_LABEL_LEN_RST = 8'd63;

    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'h2D;

    // register index, taken from paddr[2]
    localparam logic REG_MAX_NAME_LEN  = 1'b0;
    localparam logic REG_MAX_LABEL_LEN = 1'b1;

    typedef struct packed {
        logic [NAME_LEN_W-1:0]  max_name_len;
        logic [LABEL_LEN_W-1:0] max_label_len;
    } dnv_cfg_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              is_empty;
    } dnv_item_t;

    typedef enum logic [1:0] {
        CC_DOT,
        CC_HYPHEN,
        CC_ALNUM,
        CC_OTHER
    } dnv_char_class_t;

    function automatic dnv_char_class_t dnv_classify(input logic [CHAR_W-1:0] ch);
        dnv_char_class_t cc;
        if (ch == CH_DOT)
            cc = CC_DOT;
        else if (ch == CH_HYPHEN)
            cc = CC_HYPHEN;
        else if (ch inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]})
            cc = CC_ALNUM;
        else
            cc = CC_OTHER;
        return cc;
    endfunction

endpackage

`default_nettype wire

[sv/domain_name_validator.sv]
// top level of the streaming domain name syntax checker
// Checks a domain name that arrives one ASCII byte per transfer on the slave
// stream, tlast on the final byte, and returns one result transfer per name
// whose bit 0 is 1 when the name is well formed. A name passes when it is
// not empty, holds at most max_name_length characters and at least one dot,
// every label is non-empty and at most max_label_length characters, labels
// hold only letters, digits and hyphens, and no hyphen starts or ends a label.
// An empty name is sent as a single transfer with tuser set and tlast set and
// always fails; tuser without tlast is dropped. A byte is taken every cycle
// unless the input stalls: one input register feeds the per-name counters
// and flags, and the result lands in an output register, so throughput is
// one byte per clock when not stalled; a result is offered on m_tvalid from
// the result register after its last byte leaves the input register. The
// input stalls only when a last byte waits in the input register, the result
// register is still full and m_tready is low; non-last bytes there never wait.
// Limits sit at apb byte addresses 0 (max_name_length, reset 253) and 4
// (max_label_length, reset 63); change them only while no name is in flight.
`default_nettype none

module domain_name_validator (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // apb configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [dnv_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [dnv_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [dnv_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    // byte stream in
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [dnv_pkg::CHAR_W-1:0]     s_tdata,   // [7:0] ch
    input  wire logic                           s_tlast,   // last byte of the name
    input  wire logic                           s_tuser,   // [0] is_empty
    // result stream out
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [dnv_pkg::OUT_DATA_W-1:0] m_tdata    // [0] valid_res, [7:1] zero
);
    import dnv_pkg::*;

    dnv_cfg_t  cfg;
    dnv_item_t in_item_reg;
    logic      in_valid_reg;
    logic      out_valid_reg;
    logic      out_res_reg;
    logic      step;
    logic      out_free;
    logic      core_res;
    logic      s_xfer;
    logic      m_xfer;

    dnv_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // result register is free when empty or being drained this cycle
    assign m_xfer   = m_tvalid && m_tready;
    assign out_free = !out_valid_reg || m_tready;

    // a non-last byte always moves on; a last byte needs room for its result
    assign step     = in_valid_reg && (!in_item_reg.last || out_free);
    assign s_tready = !in_valid_reg || step;
    assign s_xfer   = s_tvalid && s_tready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_item_reg.ch       <= s_tdata;
            in_item_reg.last     <= s_tlast;
            in_item_reg.is_empty <= s_tuser;
        end
    end

    dnv_name_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (in_item_reg),
        .cfg       (cfg),
        .valid_res (core_res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && in_item_reg.last)
            out_valid_reg <= 1'b1;
        else if (m_xfer)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && in_item_reg.last)
            out_res_reg <= core_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_res_reg};

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && in_item_reg.last && out_valid_reg)
        else $error("input stalled without a waiting result");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step && in_item_reg.last))
        else $error("result appeared without a last byte");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        step && in_item_reg.last |-> out_free)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

[sv/dnv_cfg_regs.sv]
// apb register file holding the name and label length limits
`default_nettype none

module dnv_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [dnv_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [dnv_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [dnv_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output dnv_pkg::dnv_cfg_t                   cfg
);
    import dnv_pkg::*;

    logic [NAME_LEN_W-1:0]  max_name_len_reg;
    logic [LABEL_LEN_W-1:0] max_label_len_reg;
    logic                   wr_en;
    logic                   reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_name_len_reg  <= MAX_NAME_LEN_RST;
            max_label_len_reg <= MAX_LABEL_LEN_RST;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_MAX_NAME_LEN)
                max_name_len_reg <= pwdata[NAME_LEN_W-1:0];
            else
                max_label_len_reg <= pwdata[LABEL_LEN_W-1:0];
        end
    end

    always_comb
    begin
        if (reg_sel == REG_MAX_NAME_LEN)
            prdata = {{(APB_DATA_W-NAME_LEN_W){1'b0}}, max_name_len_reg};
        else
            prdata = {{(APB_DATA_W-LABEL_LEN_W){1'b0}}, max_label_len_reg};
    end

    assign cfg.max_name_len  = max_name_len_reg;
    assign cfg.max_label_len = max_label_len_reg;

endmodule

`default_nettype wire

[sv/dnv_name_state.sv]
// per-name counters and flags, updated once per processed byte
`default_nettype none

module dnv_name_state (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire dnv_pkg::dnv_item_t  item,
    input  wire dnv_pkg::dnv_cfg_t   cfg,
    output logic                     valid_res
);
    import dnv_pkg::*;

    logic [LABEL_LEN_W-1:0] label_count_reg, label_count_next;
    logic [NAME_LEN_W-1:0]  total_count_reg, total_count_next;
    logic                   failed_reg, failed_next;
    logic                   seen_dot_reg, seen_dot_next;
    logic                   hyphen_pending_reg, hyphen_pending_next;

    dnv_char_class_t        cc;
    logic [LABEL_LEN_W-1:0] lbl;
    logic [NAME_LEN_W-1:0]  tot;
    logic                   fl;
    logic                   sd;
    logic                   hp;

    assign cc = dnv_classify(item.ch);

    always_comb
    begin
        lbl       = label_count_reg;
        tot       = total_count_reg;
        fl        = failed_reg;
        sd        = seen_dot_reg;
        hp        = hyphen_pending_reg;
        valid_res = 1'b0;

        if (!item.is_empty)
        begin
            // name length, saturating at the limit
            if (tot >= cfg.max_name_len)
                fl = 1'b1;
            else
                tot = tot + 1'b1;

            // hyphen directly before a dot
            if (hp && cc == CC_DOT)
                fl = 1'b1;
            hp = 1'b0;

            case (cc)
                CC_DOT:
                begin
                    if (lbl == '0)
                        fl = 1'b1;
                    lbl = '0;
                    sd  = 1'b1;
                end
                CC_ALNUM:
                begin
                    if (lbl >= cfg.max_label_len)
                        fl = 1'b1;
                    else
                        lbl = lbl + 1'b1;
                end
                CC_HYPHEN:
                begin
                    if (lbl == '0)
                        fl = 1'b1;
                    else if (lbl >= cfg.max_label_len)
                        fl = 1'b1;
                    else
                        lbl = lbl + 1'b1;
                    hp = 1'b1;
                end
                default:
                begin
                    fl = 1'b1;
                end
            endcase

            // end of name: trailing hyphen, empty last label, no dot
            if (item.last && (hp || lbl == '0 || !sd))
                fl = 1'b1;
            valid_res = !fl;
        end

        label_count_next    = lbl;
        total_count_next    = tot;
        failed_next         = fl;
        seen_dot_next       = sd;
        hyphen_pending_next = hp;

        if (item.last)
        begin
            label_count_next    = '0;
            total_count_next    = '0;
            failed_next         = 1'b0;
            seen_dot_next       = 1'b0;
            hyphen_pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_count_reg    <= '0;
            total_count_reg    <= '0;
            failed_reg         <= 1'b0;
            seen_dot_reg       <= 1'b0;
            hyphen_pending_reg <= 1'b0;
        end
        else if (step)
        begin
            label_count_reg    <= label_count_next;
            total_count_reg    <= total_count_next;
            failed_reg         <= failed_next;
            seen_dot_reg       <= seen_dot_next;
            hyphen_pending_reg <= hyphen_pending_next;
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.last |=> label_count_reg == '0 && total_count_reg == '0
            && !failed_reg && !seen_dot_reg && !hyphen_pending_reg)
        else $error("name state not cleared after last byte");

    a_pass_needs_dot: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.last && valid_res |-> seen_dot_reg || cc == CC_DOT)
        else $error("name passed without any dot");

    a_empty_fails: assert property (@(posedge clk) disable iff (!rst_n)
        item.is_empty |-> !valid_res)
        else $error("empty name reported as valid");

endmodule

`default_nettype wire

[verif/testbench.sv]
// self-checking stream testbench for the domain name validator
module testbench;
    import dnv_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 6;     // idle margin after the last verdict
    localparam int PHASE_ITEMS   = 35;    // minimum accepted bytes per random limit setting
    localparam int MAX_REPORTS   = 25;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [CHAR_W-1:0]     s_tdata  = '0;   // [7:0] ch
    logic                  s_tlast  = 1'b0;
    logic                  s_tuser  = 1'b0; // [0] is_empty
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // [0] valid_res, [7:1] zero

    // shadow copy of the limit registers
    logic [NAME_LEN_W-1:0]  cfg_name_max  = MAX_NAME_LEN_RST;
    logic [LABEL_LEN_W-1:0] cfg_label_max = MAX_LABEL_LEN_RST;

    // per-name tracking state, cleared after every verdict
    logic [LABEL_LEN_W-1:0] lbl_len   = '0;
    logic [NAME_LEN_W-1:0]  name_len  = '0;
    logic                   name_bad  = 1'b0;
    logic                   dot_seen  = 1'b0;
    logic                   dash_open = 1'b0;

    // verdicts still owed by the block, oldest first
    logic verdicts_due[$];
    // bytes of the name being assembled for sending
    logic [CHAR_W-1:0] name_buf[$];

    // idling controls, written by the test tasks only
    bit tx_steady   = 1'b0;
    bit rx_steady   = 1'b0;
    bit hold_toggle = 1'b0;

    // receiver-owned counters
    bit hold_seen   = 1'b0;
    int hold_left   = 0;
    int rx_gap_left = 0;

    int cycle_count    = 0;
    int items_sent     = 0;
    int names_checked  = 0;
    int names_passed   = 0;
    int mismatch_count = 0;
    int settings_used  = 0;
    logic [OUT_DATA_W-1:0] want;

    domain_name_validator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #HALF_PERIOD clk = ~clk;

    // gap length: usually a short one, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic dnv_char_class_t char_kind(input logic [CHAR_W-1:0] c);
        if (c == CH_DOT)
            return CC_DOT;
        if (c == CH_HYPHEN)
            return CC_HYPHEN;
        if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
            return CC_ALNUM;
        return CC_OTHER;
    endfunction

    function automatic logic [CHAR_W-1:0] rand_alnum();
        case ($urandom_range(0, 2))
            0:       return CHAR_W'(8'h30 + $urandom_range(0, 9));
            1:       return CHAR_W'(8'h41 + $urandom_range(0, 25));
            default: return CHAR_W'(8'h61 + $urandom_range(0, 25));
        endcase
    endfunction

    // one more character in the current label, saturating at the label limit
    function automatic void label_grow();
        if (lbl_len >= cfg_label_max)
            name_bad = 1'b1;
        else
            lbl_len++;
    endfunction

    function automatic void name_clear();
        lbl_len   = '0;
        name_len  = '0;
        name_bad  = 1'b0;
        dot_seen  = 1'b0;
        dash_open = 1'b0;
    endfunction

    // advance the name tracker by one accepted byte and queue the verdict on tlast
    function automatic void track_byte(input logic [CHAR_W-1:0] c, input logic lst,
                                       input logic emp);
        dnv_char_class_t kind;
        kind = char_kind(c);
        if (emp)
        begin
            // empty marker without tlast is dropped, with tlast it is a failed name
            if (lst)
            begin
                name_clear();
                verdicts_due.push_back(1'b0);
            end
            return;
        end
        if (name_len >= cfg_name_max)
            name_bad = 1'b1;
        else
            name_len++;
        // a pending hyphen is settled by the byte after it
        if (dash_open && kind == CC_DOT)
            name_bad = 1'b1;
        dash_open = 1'b0;
        case (kind)
            CC_DOT:
            begin
                if (lbl_len == 0)
                    name_bad = 1'b1;
                lbl_len  = '0;
                dot_seen = 1'b1;
            end
            CC_ALNUM:
                label_grow();
            CC_HYPHEN:
            begin
                if (lbl_len == 0)
                    name_bad = 1'b1;
                else
                    label_grow();
                dash_open = 1'b1;
            end
            default:
                name_bad = 1'b1;
        endcase
        if (lst)
        begin
            if (dash_open || lbl_len == 0 || !dot_seen)
                name_bad = 1'b1;
            verdicts_due.push_back(!name_bad);
            name_clear();
        end
    endfunction

    // offer one byte transfer and hold it until the block takes it
    task automatic send_item(input logic [CHAR_W-1:0] c, input logic lst, input logic emp);
        int gap;
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = c;
        s_tlast  = lst;
        s_tuser  = emp;
        do
            @(posedge clk);
        while (!s_tready);
        track_byte(c, lst, emp);
        if (!(emp && !lst))
            items_sent++;
        if (!tx_steady && $urandom_range(0, 3) == 0)
        begin
            gap = pick_gap();
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // send name_buf with tlast on its final byte, or close it with an empty marker
    task automatic send_name_buf(input logic end_empty);
        int i;
        for (i = 0; i < name_buf.size(); i++)
        begin
            // stray empty marker without tlast, which the block must drop
            if ($urandom_range(0, 19) == 0)
                send_item(CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b1);
            send_item(name_buf[i], !end_empty && i == name_buf.size() - 1, 1'b0);
        end
        if (end_empty)
            send_item(CHAR_W'($urandom_range(0, 255)), 1'b1, 1'b1);
    endtask

    task automatic send_text(input string txt);
        int i;
        name_buf.delete();
        for (i = 0; i < txt.len(); i++)
            name_buf.push_back(txt[i]);
        send_name_buf(1'b0);
    endtask

    // label of letters and digits, with hyphens only away from its ends
    task automatic push_label(input int len);
        int i;
        for (i = 0; i < len; i++)
        begin
            if (i > 0 && i < len - 1 && $urandom_range(0, 5) == 0)
                name_buf.push_back(CH_HYPHEN);
            else
                name_buf.push_back(rand_alnum());
        end
    endtask

    // usually dotted name whose labels sit mostly inside, sometimes at or just past the limit
    task automatic build_wellformed();
        int labels, j, len, hi;
        labels = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 4);
        hi = (cfg_label_max == 0) ? 1 : ((cfg_label_max < 6) ? cfg_label_max : 6);
        for (j = 0; j < labels; j++)
        begin
            if (j > 0)
                name_buf.push_back(CH_DOT);
            case ($urandom_range(0, 9))
                0:       len = (cfg_label_max <= 20) ? cfg_label_max + 1 : hi;
                1:       len = (cfg_label_max <= 20) ? cfg_label_max : hi;
                default: len = $urandom_range(1, hi);
            endcase
            push_label((len < 1) ? 1 : len);
        end
    endtask

    task automatic send_random_name();
        int pick, n, i, pos, k, target;
        logic end_empty;
        name_buf.delete();
        end_empty = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 60 || (pick < 72 && cfg_name_max > 24))
            build_wellformed();
        else if (pick < 72)
        begin
            // total length right at the name limit or one past it
            target = cfg_name_max + $urandom_range(0, 1);
            if (target < 1)
                target = 1;
            k = (cfg_label_max == 0) ? 1 : ((cfg_label_max < 3) ? cfg_label_max : 3);
            pos = 0;
            for (i = 0; i < target; i++)
            begin
                if (pos == k && i != target - 1)
                begin
                    name_buf.push_back(CH_DOT);
                    pos = 0;
                end
                else
                begin
                    name_buf.push_back(rand_alnum());
                    pos++;
                end
            end
        end
        else if (pick < 84)
        begin
            // good shape with one byte spoilt
            build_wellformed();
            i = $urandom_range(0, name_buf.size() - 1);
            case ($urandom_range(0, 2))
                0:       name_buf[i] = CH_DOT;
                1:       name_buf[i] = CH_HYPHEN;
                default: name_buf[i] = CHAR_W'($urandom_range(0, 255));
            endcase
        end
        else if (pick < 96)
        begin
            // short run of arbitrary bytes, sometimes abandoned by an empty marker
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 3))
                    0:       name_buf.push_back(CHAR_W'($urandom_range(0, 255)));
                    1:       name_buf.push_back(CH_DOT);
                    2:       name_buf.push_back(CH_HYPHEN);
                    default: name_buf.push_back(rand_alnum());
                endcase
            end
            end_empty = ($urandom_range(0, 3) == 0);
        end
        else
            end_empty = 1'b1;
        send_name_buf(end_empty);
    endtask

    // stop offering and let every owed verdict come back
    task automatic wait_drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // setup cycle, then access cycle; the register takes the value at the access edge
    task automatic apb_write(input logic reg_idx, input logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (reg_idx == REG_MAX_NAME_LEN)
            cfg_name_max = value[NAME_LEN_W-1:0];
        else
            cfg_label_max = value[LABEL_LEN_W-1:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_limits(input int name_max, input int label_max);
        wait_drain();
        apb_write(REG_MAX_NAME_LEN, name_max);
        apb_write(REG_MAX_LABEL_LEN, label_max);
        settings_used++;
    endtask

    // hand-picked names under the reset limits
    task automatic test_directed();
        // hyphen inside a label, with a dropped empty marker while it is pending
        send_item("a", 1'b0, 1'b0);
        send_item(CH_HYPHEN, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item("b", 1'b0, 1'b0);
        send_item(CH_DOT, 1'b0, 1'b0);
        send_item("c", 1'b1, 1'b0);
        send_text("-a.b");   // hyphen opening a label
        send_text("a-.b");   // hyphen closing a label
        send_text("zZ9");    // no dot at all
        send_text("a..");    // doubled dot and trailing dot
        send_text("Q.b-");   // hyphen at the very end
        // zero byte and top byte are not label characters
        name_buf.delete();
        name_buf.push_back(8'h00);
        name_buf.push_back(CH_DOT);
        name_buf.push_back(8'hFF);
        send_name_buf(1'b0);
        // partial name thrown away by an empty name
        send_item("x", 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
    endtask

    // receiver holds off while short names keep coming, then the sender waits for all
    task automatic test_backpressure();
        int n;
        tx_steady   = 1'b1;
        rx_steady   = 1'b1;
        hold_toggle = ~hold_toggle;
        for (n = 0; n < 24; n++)
        begin
            name_buf.delete();
            push_label($urandom_range(1, 3));
            name_buf.push_back(CH_DOT);
            push_label($urandom_range(1, 3));
            send_name_buf(1'b0);
        end
        wait_drain();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // random names under a sweep of limit settings, extremes included
    task automatic test_random_limits();
        int k, nm, lb, first;
        for (k = 0; k < 10; k++)
        begin
            case (k)
                0:       begin nm = 1;    lb = 1;   end
                1:       begin nm = 0;    lb = 0;   end
                2:       begin nm = 3;    lb = 2;   end
                3:       begin nm = 7;    lb = 3;   end
                4:       begin nm = 12;   lb = 4;   end
                5:       begin nm = 24;   lb = 6;   end
                6:       begin nm = 8;    lb = 255; end
                7:       begin nm = 1000; lb = 1;   end
                8:       begin nm = 40;   lb = 10;  end
                default: begin nm = 253;  lb = 63;  end
            endcase
            set_limits(nm, lb);
            // some phases run without idling on one side or both
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            first = items_sent;
            while (items_sent - first < PHASE_ITEMS)
                send_random_name();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // widest label limit: label right at 255 characters and one past it
    task automatic test_long_names();
        int len;
        set_limits(1000, 255);
        for (len = 255; len <= 256; len++)
        begin
            name_buf.delete();
            push_label(len);
            name_buf.push_back(CH_DOT);
            push_label(1);
            send_name_buf(1'b0);
        end
    endtask

    task automatic note_mismatch(input string what, input logic [OUT_DATA_W-1:0] exp_v,
                                 input logic [OUT_DATA_W-1:0] act_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s, expected %h, actual %h", $time, what, exp_v, act_v);
    endtask

    // receiver: random stalls, plus the long hold-off counted here
    always @(negedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            m_tready = 1'b0;
            hold_left--;
        end
        else if (rx_gap_left > 0)
        begin
            m_tready = 1'b0;
            rx_gap_left--;
        end
        else if (!rx_steady && $urandom_range(0, 3) == 0)
        begin
            m_tready    = 1'b0;
            rx_gap_left = pick_gap() - 1;
        end
        else
            m_tready = 1'b1;
    end

    // result checker: every result transfer against the oldest owed verdict
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdicts_due.size() == 0)
                note_mismatch("result with no name pending", '0, m_tdata);
            else
            begin
                want = {{(OUT_DATA_W-1){1'b0}}, verdicts_due.pop_front()};
                names_checked++;
                if (want[0])
                    names_passed++;
                if (m_tdata !== want)
                    note_mismatch("verdict mismatch", want, m_tdata);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run stopped at the cycle limit, %0d verdicts outstanding",
                     $time, verdicts_due.size());
            $display("testbench failed");
            $finish;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_backpressure();
        test_random_limits();
        test_long_names();
        wait_drain();
        $display("covered %0d name bytes over %0d limit settings", items_sent, settings_used);
        $display("checked %0d verdicts, %0d of them passing names", names_checked,
                 names_passed);
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
